### rtl/core/compressed_bitmap_index_decoder_assert.svh
// Assertion macros for the compressed bitmap index decoder.
// Used by the top level; needs nothing but a clock and an active-low reset.
`ifndef COMPRESSED_BITMAP_INDEX_DECODER_ASSERT_SVH
`define COMPRESSED_BITMAP_INDEX_DECODER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CBID_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CBID_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### rtl/core/cbid_pkg.sv
// Shared types and constants of the compressed bitmap index decoder.
// No dependencies; compiled before every other file of the block.
package cbid_pkg;

  // decoder phase codes
  localparam logic [1:0] PH_CTRL = 2'd0;  // expect a control byte
  localparam logic [1:0] PH_CNT  = 2'd1;  // expect the low count byte
  localparam logic [1:0] PH_LIT  = 2'd2;  // inside a literal run

  // mode register codes
  localparam logic [1:0] MODE_LIST = 2'd0;

  // configuration register indexes
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  localparam int BYTE_POS_W = 29;
  localparam int REP_W      = 13;
  localparam int RUN_W      = 14;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // output queue geometry
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QLVL_W = 3;

  // stream state, apart from the position counter
  typedef struct packed {
    logic [1:0]       phase;
    logic             run_is_lit;
    logic             fill_ones;
    logic [RUN_W-1:0] run_rem;
    logic [31:0]      set_total;
    logic             seen_any;
    logic             limit_hit;
  } st_t;

  // one result word
  typedef struct packed {
    logic [BYTE_POS_W-1:0] byte_pos;
    logic [7:0]            byte_value;
    logic [REP_W-1:0]      repeat_bytes;
    logic [31:0]           bit_total;
    logic                  found;
    logic                  overflow;
    logic                  final_res;
  } res_t;

  // output queue status
  typedef struct packed {
    logic [QLVL_W-1:0] level;
  } qstat_t;

endpackage

### rtl/core/cbid_if.sv
// Valid/ready channel interfaces of the compressed bitmap index decoder.
// Depends on cbid_pkg for the result field widths.
interface cbid_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

interface cbid_out_if
  import cbid_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [BYTE_POS_W-1:0] byte_pos;
  logic [7:0]            byte_value;
  logic [REP_W-1:0]      repeat_bytes;
  logic [31:0]           bit_total;
  logic                  found;
  logic                  overflow;
  logic                  final_res;

  modport source(output valid, byte_pos, byte_value, repeat_bytes, bit_total, found,
                 overflow, final_res, input ready);
  modport sink(input valid, byte_pos, byte_value, repeat_bytes, bit_total, found,
               overflow, final_res, output ready);
endinterface

### rtl/core/cbid_decode.sv
// Per-word decode step: next stream state and up to two result words.
// Purely combinational; depends on cbid_pkg.
module cbid_decode
  import cbid_pkg::*;
#(
  parameter int POSITION_BITS = 29
) (
  input  st_t                      st,
  input  logic [POSITION_BITS-1:0] pos,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  input  logic [1:0]               mode,
  input  logic [31:0]              limit,
  output st_t                      st_nxt,
  output logic [POSITION_BITS-1:0] pos_nxt,
  output logic                     data_v,
  output res_t                     data_res,
  output logic                     fin_v,
  output res_t                     fin_res
);

  // adder wide enough for the position and any run length
  localparam int SW = (POSITION_BITS > RUN_W) ? POSITION_BITS : RUN_W;

  st_t                      s;
  logic [POSITION_BITS-1:0] p;
  logic [SW-1:0]            pos_sum;
  logic [RUN_W-1:0]         pos_delta;
  logic                     lit_go;
  logic [RUN_W-1:0]         lit_cnt;
  logic                     fill_go;
  logic [REP_W-1:0]         fill_cnt;
  logic                     byte_go;
  logic [RUN_W-1:0]         rem_dec;
  logic                     add_en;
  logic [15:0]              add_k;
  logic [32:0]              sum;
  logic [3:0]               pop;
  logic                     list_mode;
  logic [7:0]               d_val;
  logic [REP_W-1:0]         d_rep;
  logic [BYTE_POS_W-1:0]    d_pos_w;
  logic [BYTE_POS_W-1:0]    f_pos_w;

  assign list_mode = (mode == MODE_LIST);
  assign rem_dec   = st.run_rem - RUN_W'(1);

  // popcount of a literal byte
  always_comb begin
    pop = '0;
    for (int i = 0; i < 8; i++) begin
      pop = pop + {3'b000, data_byte[i]};
    end
  end

  // byte position output is a fixed 29-bit field
  generate
    if (POSITION_BITS >= BYTE_POS_W) begin : g_pos_trunc
      assign d_pos_w = pos[BYTE_POS_W-1:0];
      assign f_pos_w = p[BYTE_POS_W-1:0];
    end else begin : g_pos_ext
      assign d_pos_w = {{(BYTE_POS_W-POSITION_BITS){1'b0}}, pos};
      assign f_pos_w = {{(BYTE_POS_W-POSITION_BITS){1'b0}}, p};
    end
  endgenerate

  // classify the word by phase
  always_comb begin
    lit_go   = 1'b0;
    lit_cnt  = '0;
    fill_go  = 1'b0;
    fill_cnt = '0;
    byte_go  = 1'b0;
    s        = st;
    unique case (st.phase)
      PH_CTRL: begin
        if (data_byte[7]) begin
          s.run_is_lit = 1'b1;
          if (data_byte[6]) begin
            s.run_rem = {8'b0, data_byte[5:0]};
            s.phase   = PH_CNT;
          end else begin
            lit_go  = 1'b1;
            lit_cnt = {8'b0, data_byte[5:0]};
          end
        end else begin
          s.run_is_lit = 1'b0;
          s.fill_ones  = data_byte[6];
          if (data_byte[5]) begin
            s.run_rem = {9'b0, data_byte[4:0]};
            s.phase   = PH_CNT;
          end else begin
            fill_go  = 1'b1;
            fill_cnt = {8'b0, data_byte[4:0]};
          end
        end
      end
      PH_CNT: begin
        if (st.run_is_lit) begin
          lit_go  = 1'b1;
          lit_cnt = {st.run_rem[5:0], data_byte};
        end else begin
          fill_go  = 1'b1;
          fill_cnt = {st.run_rem[4:0], data_byte};
        end
      end
      default: begin
        byte_go = 1'b1;
      end
    endcase
  end

  // apply the run start, fill or literal byte
  always_comb begin
    st_nxt    = s;
    pos_delta = '0;
    add_en    = 1'b0;
    add_k     = '0;
    data_v    = 1'b0;
    d_val     = '0;
    d_rep     = '0;
    if (lit_go) begin
      st_nxt.run_is_lit = 1'b1;
      st_nxt.run_rem    = lit_cnt;
      st_nxt.phase      = (lit_cnt != '0) ? PH_LIT : PH_CTRL;
    end
    if (fill_go) begin
      st_nxt.run_is_lit = 1'b0;
      st_nxt.run_rem    = '0;
      st_nxt.phase      = PH_CTRL;
      pos_delta         = {1'b0, fill_cnt};
      if (s.fill_ones && fill_cnt != '0) begin
        add_en = 1'b1;
        add_k  = {fill_cnt, 3'b000};
        data_v = list_mode;
        d_val  = BYTE_ONES;
        d_rep  = fill_cnt;
      end
    end
    if (byte_go) begin
      pos_delta      = RUN_W'(1);
      add_en         = 1'b1;
      add_k          = {12'b0, pop};
      data_v         = list_mode && (data_byte != '0);
      d_val          = data_byte;
      d_rep          = REP_W'(1);
      st_nxt.run_rem = rem_dec;
      if (rem_dec == '0) begin
        st_nxt.phase = PH_CTRL;
      end
    end
    // saturating set-bit total and sticky flags
    sum = {1'b0, st.set_total} + {17'b0, add_k};
    if (add_en) begin
      if (add_k != '0) begin
        st_nxt.seen_any = 1'b1;
      end
      if (sum > {1'b0, limit}) begin
        st_nxt.limit_hit = 1'b1;
      end
      st_nxt.set_total = sum[32] ? '1 : sum[31:0];
    end
  end

  assign pos_sum = SW'(pos) + SW'(pos_delta);
  assign p       = pos_sum[POSITION_BITS-1:0];

  // result words
  always_comb begin
    data_res.byte_pos     = d_pos_w;
    data_res.byte_value   = d_val;
    data_res.repeat_bytes = d_rep;
    data_res.bit_total    = st_nxt.set_total;
    data_res.found        = st_nxt.seen_any;
    data_res.overflow     = list_mode && st_nxt.limit_hit;
    data_res.final_res    = 1'b0;
    fin_res               = data_res;
    fin_res.byte_pos      = f_pos_w;
    fin_res.byte_value    = '0;
    fin_res.repeat_bytes  = '0;
    fin_res.final_res     = 1'b1;
  end

  assign fin_v = last_byte;

  // the closing word clears the stream; next step is written by the caller
  assign pos_nxt = last_byte ? '0 : p;

endmodule

### rtl/core/cbid_outq.sv
// Small result queue: takes up to two words per cycle, gives one per cycle while popped.
// Depends on cbid_pkg for the word type and depth.
module cbid_outq
  import cbid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push0,
  input  res_t       push1,
  input  logic       pop,
  output res_t       head,
  output qstat_t     stat
);

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r;
  logic [QPTR_W-1:0] wr_nxt;
  logic [QPTR_W-1:0] rd_r;
  logic [QPTR_W-1:0] rd_nxt;
  logic [QLVL_W-1:0] lvl_r;
  logic [QLVL_W-1:0] lvl_nxt;
  logic [QPTR_W-1:0] wr_1;

  assign wr_1    = wr_r + QPTR_W'(1);
  assign wr_nxt  = wr_r + QPTR_W'(push_n);
  assign rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
  assign lvl_nxt = lvl_r + QLVL_W'(push_n) - QLVL_W'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_1] <= push1;
    end
  end

  assign head       = mem_r[rd_r];
  assign stat.level = lvl_r;

endmodule

### rtl/core/compressed_bitmap_index_decoder.sv
// Top level of the compressed bitmap index decoder.
// Depends on cbid_pkg, cbid_if, cbid_decode, cbid_outq and the assertion header.
//
// Decodes a byte-aligned compressed bitmap, one stream byte per input word.
// in_ch carries data_byte and last_byte; a word moves when valid and ready
// are both high. out_ch carries result words: in list mode one per nonzero
// literal byte and one per nonempty ones-fill run, and in every mode one
// closing word (final_res set) after the byte marked last, which also
// resets the stream state. Configuration (mode, result_limit) is written
// through cfg_we/cfg_index/cfg_wdata; the user must do so only while the
// block is idle; the block does not enforce this. Each input word is
// decoded in the cycle it is taken; its results are registered in a
// four-word output queue that feeds out_ch. Throughput is one input word
// per cycle while out_ch is ready and each word makes at most one result;
// a word that makes two results costs an extra output slot, since the queue
// drains one word per cycle. in_ch.ready is high while the queue has room
// for two words, so a stalled receiver fills the queue and then holds off
// the input; nothing is dropped. Synchronous active-low reset clears the
// stream state, the queue and the registers (mode list, limit all ones).
`include "compressed_bitmap_index_decoder_assert.svh"

module compressed_bitmap_index_decoder
  import cbid_pkg::*;
#(
  parameter int POSITION_BITS = 29
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  cbid_in_if.sink            in_ch,
  cbid_out_if.source         out_ch
);

  logic [1:0]               mode_r;
  logic [31:0]              limit_r;
  st_t                      st_r;
  st_t                      st_nxt;
  st_t                      st_dec;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic                     in_acc;
  logic                     data_v;
  logic                     fin_v;
  res_t                     data_res;
  res_t                     fin_res;
  logic [1:0]               push_n;
  res_t                     push0;
  res_t                     head;
  qstat_t                   q_stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_LIST;
      limit_r <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[1:0];
        CFG_LIMIT: limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (q_stat.level <= QLVL_W'(QDEPTH - 2));
  assign in_acc      = in_ch.valid && in_ch.ready;

  cbid_decode #(
    .POSITION_BITS(POSITION_BITS)
  ) u_decode (
    .st        (st_r),
    .pos       (pos_r),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .mode      (mode_r),
    .limit     (limit_r),
    .st_nxt    (st_dec),
    .pos_nxt   (pos_nxt),
    .data_v    (data_v),
    .data_res  (data_res),
    .fin_v     (fin_v),
    .fin_res   (fin_res)
  );

  // closing word returns the stream to its reset state
  assign st_nxt = fin_v ? '0 : st_dec;

  // stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      pos_r <= '0;
    end else if (in_acc) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

  // queue the words of this input
  assign push_n = in_acc ? ({1'b0, data_v} + {1'b0, fin_v}) : 2'd0;
  assign push0  = data_v ? data_res : fin_res;

  cbid_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .push0  (push0),
    .push1  (fin_res),
    .pop    (out_ch.valid && out_ch.ready),
    .head   (head),
    .stat   (q_stat)
  );

  assign out_ch.valid        = (q_stat.level != '0);
  assign out_ch.byte_pos     = head.byte_pos;
  assign out_ch.byte_value   = head.byte_value;
  assign out_ch.repeat_bytes = head.repeat_bytes;
  assign out_ch.bit_total    = head.bit_total;
  assign out_ch.found        = head.found;
  assign out_ch.overflow     = head.overflow;
  assign out_ch.final_res    = head.final_res;

  // checks
  `CBID_ASSERT_IMPLY(a_q_bound, clk, rst_n, 1'b1, q_stat.level <= QLVL_W'(QDEPTH), "queue overrun")
  `CBID_ASSERT_IMPLY(a_lit_rem, clk, rst_n, st_r.phase == PH_LIT, st_r.run_rem != '0, "empty literal run")
  `CBID_ASSERT_NEXT(a_fin_out, clk, rst_n, in_acc && in_ch.last_byte, out_ch.valid, "closing word lost")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for compressed_bitmap_index_decoder: drives encoded bitmap streams
// word by word and checks every result word against a built-in decoder model.
// Depends on cbid_pkg, the cbid_in_if/cbid_out_if interfaces and the decoder top level.
module tb;
  import cbid_pkg::*;

  // mode codes beyond list mode; the spare code decodes like count mode
  localparam logic [1:0] MODE_COUNT = 2'd1;
  localparam logic [1:0] MODE_ANY   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int SETTLE_CYC   = 6;     // output queue depth plus margin
  localparam int HOLD_CYCLES  = 300;   // long receiver stall
  localparam int QUIET_LIMIT  = 4000;  // cycles with no word moving on any channel
  localparam int PHASE_ITEMS  = 210;
  localparam int NUM_PHASES   = 8;
  localparam int DIR_ROWS     = 23;

  localparam res_t CLOSE_EMPTY = '{byte_pos: '0, byte_value: 8'h00, repeat_bytes: '0,
                                   bit_total: 32'd0, found: 1'b0, overflow: 1'b0,
                                   final_res: 1'b1};
  localparam res_t ONES_FILL5  = '{byte_pos: '0, byte_value: 8'hFF, repeat_bytes: 13'd5,
                                   bit_total: 32'd40, found: 1'b1, overflow: 1'b0,
                                   final_res: 1'b0};

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;  // want holds the one result of this row
    res_t       want;
  } dir_row_t;

  // directed stream: fills, literals, empty runs, long counts, cut-off streams
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, CLOSE_EMPTY},  // empty zero fill, stream closes at once
    '{8'h45, 1'b0, 1'b1, ONES_FILL5},   // ones fill of 5 bytes
    '{8'h83, 1'b0, 1'b0, '0},           // literal run of 3
    '{8'h00, 1'b0, 1'b0, '0},           // zero literal: no word
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'h1F, 1'b0, 1'b0, '0},           // zero fill of 31
    '{8'h7F, 1'b0, 1'b0, '0},           // ones fill, long count, max high part
    '{8'hFF, 1'b0, 1'b0, '0},           // count 8191
    '{8'hC0, 1'b0, 1'b0, '0},           // long literal ...
    '{8'h00, 1'b0, 1'b0, '0},           // ... of length zero
    '{8'hC1, 1'b0, 1'b0, '0},           // long literal of 258
    '{8'h02, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},           // cut short inside the literal run
    '{8'h60, 1'b1, 1'b1, CLOSE_EMPTY},  // cut short while the count byte is due
    '{8'h40, 1'b0, 1'b0, '0},           // empty ones fill
    '{8'h20, 1'b0, 1'b0, '0},           // long zero fill ...
    '{8'h00, 1'b0, 1'b0, '0},           // ... of length zero
    '{8'h81, 1'b0, 1'b0, '0},
    '{8'h55, 1'b1, 1'b0, '0},
    '{8'hFE, 1'b0, 1'b0, '0},           // long literal, large high count
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  cbid_in_if  in_ch ();
  cbid_out_if out_ch ();

  compressed_bitmap_index_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // decoder model state and register shadows
  logic [1:0]            dm_phase;
  logic                  dm_lit;
  logic                  dm_ones;
  logic [RUN_W-1:0]      dm_run;
  logic [BYTE_POS_W-1:0] dm_pos;
  logic [31:0]           dm_total;
  logic                  dm_seen;
  logic                  dm_hit;
  logic [1:0]            sh_mode;
  logic [31:0]           sh_limit;

  res_t step_res [2];
  int   step_n;
  res_t pending_q [$];

  int n_errors = 0;
  int n_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs = 0;
  int quiet = 0;

  function automatic void clear_stream();
    dm_phase = PH_CTRL;
    dm_lit   = 1'b0;
    dm_ones  = 1'b0;
    dm_run   = '0;
    dm_pos   = '0;
    dm_total = '0;
    dm_seen  = 1'b0;
    dm_hit   = 1'b0;
  endfunction

  // add set bits to the running total, saturating; overflow flag is sticky
  function automatic void tally(input logic [16:0] k);
    logic [32:0] sum;
    sum = {1'b0, dm_total} + 33'(k);
    if (k != 0) dm_seen = 1'b1;
    if (sum > {1'b0, sh_limit}) dm_hit = 1'b1;
    dm_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic void emit(input logic [BYTE_POS_W-1:0] pos, input logic [7:0] val,
                               input logic [REP_W-1:0] rep, input logic fin);
    res_t r;
    r.byte_pos     = pos;
    r.byte_value   = val;
    r.repeat_bytes = rep;
    r.bit_total    = dm_total;
    r.found        = dm_seen;
    r.overflow     = (sh_mode == MODE_LIST) && dm_hit;
    r.final_res    = fin;
    step_res[step_n] = r;
    step_n++;
  endfunction

  function automatic void run_fill(input logic [REP_W-1:0] cnt);
    logic [BYTE_POS_W-1:0] start;
    start    = dm_pos;
    dm_lit   = 1'b0;
    dm_run   = '0;
    dm_phase = PH_CTRL;
    dm_pos   = dm_pos + BYTE_POS_W'(cnt);
    if (dm_ones && cnt != 0) begin
      tally({1'b0, cnt, 3'b000});
      if (sh_mode == MODE_LIST) emit(start, BYTE_ONES, cnt, 1'b0);
    end
  endfunction

  function automatic void open_literal(input logic [RUN_W-1:0] cnt);
    dm_lit   = 1'b1;
    dm_run   = cnt;
    dm_phase = (cnt != 0) ? PH_LIT : PH_CTRL;
  endfunction

  // one stream byte in, up to two result words out in step_res
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [BYTE_POS_W-1:0] start;
    logic [RUN_W-1:0]      cnt;
    step_n = 0;
    case (dm_phase)
      PH_CTRL: begin
        if (b[7]) begin
          dm_lit = 1'b1;
          if (b[6]) begin
            dm_run   = RUN_W'(b[5:0]);
            dm_phase = PH_CNT;
          end else begin
            open_literal(RUN_W'(b[5:0]));
          end
        end else begin
          dm_lit  = 1'b0;
          dm_ones = b[6];
          if (b[5]) begin
            dm_run   = RUN_W'(b[4:0]);
            dm_phase = PH_CNT;
          end else begin
            run_fill(REP_W'(b[4:0]));
          end
        end
      end
      PH_CNT: begin
        cnt = {dm_run[5:0], b};
        if (dm_lit) open_literal(cnt);
        else run_fill(cnt[REP_W-1:0]);
      end
      default: begin
        start  = dm_pos;
        dm_pos = dm_pos + 1'b1;
        tally(17'($countones(b)));
        if (sh_mode == MODE_LIST && b != 8'h00) emit(start, b, REP_W'(1), 1'b0);
        dm_run = dm_run - 1'b1;
        if (dm_run == 0) dm_phase = PH_CTRL;
      end
    endcase
    if (last) begin
      emit(dm_pos, 8'h00, '0, 1'b1);
      clear_stream();
    end
  endfunction

  // offer one word, with random gaps, and return once it is taken
  task automatic send_word(input logic [7:0] d, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic send_checked(input logic [7:0] d, input logic last);
    send_word(d, last);
    decode_byte(d, last);
    for (int k = 0; k < step_n; k++) pending_q.push_back(step_res[k]);
  endtask

  // stop offering and wait for the block to go quiet
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) sh_mode = val[1:0];
    else sh_limit = val;
  endtask

  // one well-formed stream of random runs, now and then cut short
  task automatic send_stream();
    logic [7:0] bytes_q [$];
    int         runs;
    int         kind;
    int         cnt;
    int         nlit;
    int         keep;
    logic       ones;
    logic       stop;
    logic [5:0] hi6;
    logic [7:0] lo;
    runs = $urandom_range(1, 6);
    stop = 1'b0;
    for (int r = 0; r < runs && !stop; r++) begin
      kind = $urandom_range(0, 9);
      ones = 1'($urandom_range(0, 1));
      nlit = 0;
      case (kind)
        0, 1, 2, 3: begin
          cnt = (kind == 3) ? $urandom_range(0, 63) : $urandom_range(0, 6);
          bytes_q.push_back({2'b10, 6'(cnt)});
          nlit = cnt;
        end
        4: begin
          hi6 = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'd0;
          lo  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
          bytes_q.push_back({2'b11, hi6});
          bytes_q.push_back(lo);
          cnt = {hi6, lo};
          // a huge literal run ends the stream early
          if (cnt > 12) begin
            nlit = $urandom_range(0, 8);
            stop = 1'b1;
          end else begin
            nlit = cnt;
          end
        end
        5, 6: bytes_q.push_back({1'b0, ones, 1'b0, 5'($urandom)});
        7, 8: begin
          bytes_q.push_back({1'b0, ones, 1'b1, 5'($urandom)});
          bytes_q.push_back(8'($urandom));
        end
        default: bytes_q.push_back(8'($urandom));  // stray byte
      endcase
      for (int i = 0; i < nlit; i++)
        bytes_q.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    end
    if (bytes_q.size() > 1 && $urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, bytes_q.size() - 1);
      while (bytes_q.size() > keep) void'(bytes_q.pop_back());
    end
    for (int i = 0; i < bytes_q.size(); i++)
      send_checked(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int left;
    int seen_reqs;
    left         = 0;
    seen_reqs    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != seen_reqs) begin
        seen_reqs = hold_reqs;
        left      = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // result checker: each taken word against the oldest expectation
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.byte_pos     = out_ch.byte_pos;
      got.byte_value   = out_ch.byte_value;
      got.repeat_bytes = out_ch.repeat_bytes;
      got.bit_total    = out_ch.bit_total;
      got.found        = out_ch.found;
      got.overflow     = out_ch.overflow;
      got.final_res    = out_ch.final_res;
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("%0t: unexpected result word: pos %0d value %h rep %0d final %b",
                   $time, got.byte_pos, got.byte_value, got.repeat_bytes, got.final_res);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: result mismatch (exp/got) pos %0d/%0d value %h/%h rep %0d/%0d ",
                     $time, want.byte_pos, got.byte_pos, want.byte_value, got.byte_value,
                     want.repeat_bytes, got.repeat_bytes,
                     "total %0d/%0d found %b/%b ovf %b/%b final %b/%b",
                     want.bit_total, got.bit_total, want.found, got.found,
                     want.overflow, got.overflow, want.final_res, got.final_res);
        end
      end
    end
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  md;
    logic [31:0] lim;
    int          start_cnt;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MODE;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    sh_mode         = MODE_LIST;
    sh_limit        = 32'hFFFF_FFFF;
    clear_stream();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under reset register values
    send_idle_pct = 34;
    recv_idle_pct = 50;
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_tab[i].data, dir_tab[i].last);
      decode_byte(dir_tab[i].data, dir_tab[i].last);
      if (dir_tab[i].typed) pending_q.push_back(dir_tab[i].want);
      else for (int k = 0; k < step_n; k++) pending_q.push_back(step_res[k]);
    end
    drain();

    // random part, one register setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin md = MODE_LIST;  lim = 32'hFFFF_FFFF; end
        1: begin md = MODE_LIST;  lim = 32'd0; end
        2: begin md = MODE_LIST;  lim = $urandom_range(50, 3000); end
        3: begin md = MODE_COUNT; lim = 32'd0; end
        4: begin md = MODE_ANY;   lim = $urandom; end
        5: begin md = MODE_SPARE; lim = 32'd100; end
        6: begin md = MODE_LIST;  lim = $urandom; end
        default: begin md = MODE_LIST; lim = 32'hFFFF_FFFF; end
      endcase
      write_reg(CFG_MODE, {30'd0, md});
      write_reg(CFG_LIMIT, lim);
      if (ph < 3) begin
        send_idle_pct = 34;
        recv_idle_pct = 50;
      end else if (ph < 6) begin
        send_idle_pct = 50;
        recv_idle_pct = 34;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // back-pressure: receiver stalls while words keep coming
      if (ph == 6) hold_reqs++;
      start_cnt = n_sent;
      while (n_sent - start_cnt < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4))
            send_checked(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
          send_stream();
        end
      end
      drain();
    end

    if (n_errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cbid_pkg.sv
rtl/core/cbid_if.sv
rtl/core/cbid_decode.sv
rtl/core/cbid_outq.sv
rtl/core/compressed_bitmap_index_decoder.sv
tb/sv/tb.sv
